// ===== rtl/core/ptts_pkg.sv =====
// Shared types and constants of the periodic task tick scheduler.
// Depends on nothing; every other file of the block imports it.
package ptts_pkg;

    // Number of schedule slots (1 to 8).
    localparam int TASKS = 8;

    localparam int TASK_W     = 3;
    localparam int TASK_EXT_W = 7;
    localparam int TASK_IDX_W = (TASKS > 1) ? $clog2(TASKS) : 1;
    localparam int DATA_W     = 32;
    localparam int ARG_W      = 8;
    localparam int DIV_CNT_W  = $clog2(DATA_W);

    localparam logic [DATA_W-1:0] TICK_TIME_RESET = DATA_W'(1000);

    typedef enum logic [1:0] {
        MODE_TICK  = 2'd0,
        MODE_CLEAR = 2'd1,
        MODE_INIT  = 2'd2,
        MODE_EXEC  = 2'd3
    } mode_t;

    // Command to the shared divider.
    typedef struct packed {
        logic              start;
        logic [DATA_W-1:0] dividend;
        logic [DATA_W-1:0] divisor;
    } div_cmd_t;

    // Answer of the shared divider.
    typedef struct packed {
        logic              done;
        logic [DATA_W-1:0] quotient;
    } div_rsp_t;

endpackage

// ===== rtl/core/ptts_if.sv =====
// Request and result channel interfaces of the periodic task tick scheduler.
// Depends on ptts_pkg.
interface ptts_req_if;
    import ptts_pkg::*;

    logic                valid;
    logic                ready;
    mode_t               mode;
    logic [TASK_W-1:0]   task_req;
    logic [DATA_W-1:0]   period_us;
    logic [DATA_W-1:0]   delay_us;
    logic                immediate_start;
    logic [ARG_W-1:0]    call_arg;

    modport source (output valid, mode, task_req, period_us, delay_us, immediate_start,
                    call_arg, input ready);
    modport sink   (input valid, mode, task_req, period_us, delay_us, immediate_start,
                    call_arg, output ready);
endinterface

interface ptts_res_if;
    import ptts_pkg::*;

    logic                valid;
    logic                ready;
    logic                fire;
    logic [TASK_W-1:0]   fired_task;
    logic [ARG_W-1:0]    fired_arg;

    modport source (output valid, fire, fired_task, fired_arg, input ready);
    modport sink   (input valid, fire, fired_task, fired_arg, output ready);
endinterface

// ===== rtl/core/ptts_div.sv =====
// Radix-2 restoring divider, one quotient bit per cycle.
// Depends on ptts_pkg. A zero divisor yields an all-ones quotient.
module ptts_div (
    input  logic               clk,
    input  logic               rst_n,
    input  ptts_pkg::div_cmd_t cmd,
    output ptts_pkg::div_rsp_t rsp
);
    import ptts_pkg::*;

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [DATA_W-1:0]    rem_reg, rem_next;
    logic [DATA_W-1:0]    quo_reg, quo_next;
    logic [DATA_W-1:0]    dvs_reg, dvs_next;
    logic [DATA_W:0]      trial;
    logic                 ge;

    // Shift the next dividend bit into the partial remainder and try the divisor.
    assign trial = {rem_reg, quo_reg[DATA_W-1]};
    assign ge    = (trial >= {1'b0, dvs_reg});

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        if (cmd.start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = '0;
            quo_next  = cmd.dividend;
            dvs_next  = cmd.divisor;
        end
        else if (busy_reg)
        begin
            rem_next = ge ? DATA_W'(trial - {1'b0, dvs_reg}) : trial[DATA_W-1:0];
            quo_next = {quo_reg[DATA_W-2:0], ge};
            cnt_next = cnt_reg + DIV_CNT_W'(1);
            if (cnt_reg == DIV_CNT_W'(DATA_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

endmodule

// ===== rtl/core/periodic_task_tick_scheduler_core.sv =====
// Top level of the periodic task tick scheduler: slot table, sequencer, result register.
// Depends on ptts_pkg, ptts_req_if, ptts_res_if and ptts_div.
//
//   Channel   Direction  Handshake            Payload
//   req       in         req.valid/req.ready  mode, task_req, period_us, delay_us,
//                                             immediate_start, call_arg
//   res       out        res.valid/res.ready  fire, fired_task, fired_arg
//   cfg       in         tick_time_we         tick_time_wdata (tick_time_us)
//
// Tick, clear-all, init and out-of-range execute requests complete in the cycle they are
// accepted; their result appears in the output register on the next cycle. An in-range
// execute request loads the shared radix-2 divider, which works out threshold / tick_time_us
// one quotient bit per iteration, and then does the compare and the table update.
// Reset clears all slots and loads tick_time_us with 1000; no clearing pass follows.
// A waiting result does not block the next request as long as the sink takes it in
// the same cycle; the block is not ready while a division is in progress.
module periodic_task_tick_scheduler_core (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          tick_time_we,
    input  logic [ptts_pkg::DATA_W-1:0]   tick_time_wdata,
    ptts_req_if.sink                      req,
    ptts_res_if.source                    res
);
    import ptts_pkg::*;

    typedef enum logic {
        ST_IDLE,
        ST_DIV
    } state_t;

    state_t state_reg, state_next;

    // Slot table. Eight entries of each, held in plain flops.
    logic [DATA_W-1:0] tick_counter_reg   [TASKS];
    logic [DATA_W-1:0] period_store_reg   [TASKS];
    logic [DATA_W-1:0] next_threshold_reg [TASKS];

    logic [DATA_W-1:0] tick_time_reg;

    // Execute context held while the divider runs.
    logic [TASK_IDX_W-1:0] exec_idx_reg, exec_idx_next;
    logic [TASK_W-1:0]     exec_task_reg, exec_task_next;
    logic [ARG_W-1:0]      exec_arg_reg, exec_arg_next;

    // Output register.
    logic              res_valid_reg, res_valid_next;
    logic              res_fire_reg, res_fire_next;
    logic [TASK_W-1:0] res_task_reg, res_task_next;
    logic [ARG_W-1:0]  res_arg_reg, res_arg_next;

    logic [TASK_EXT_W-1:0] task_ext;
    logic [TASK_IDX_W-1:0] req_idx;
    logic                  in_range;
    logic                  accept;
    logic                  res_take;
    logic                  due;
    logic [DATA_W-1:0]     init_threshold;

    div_cmd_t div_cmd;
    div_rsp_t div_rsp;

    ptts_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (div_cmd),
        .rsp   (div_rsp)
    );

    // Slots at or above TASKS are ignored but still answered.
    assign task_ext = TASK_EXT_W'(req.task_req);
    assign in_range = (task_ext < TASK_EXT_W'(TASKS));
    assign req_idx  = task_ext[TASK_IDX_W-1:0];

    assign res_take = res_valid_reg && res.ready;
    assign req.ready = (state_reg == ST_IDLE) && (!res_valid_reg || res.ready);
    assign accept    = req.valid && req.ready;

    // The first threshold wraps at 32 bits when delay and period are summed.
    assign init_threshold = req.immediate_start ? req.delay_us
                                                : DATA_W'(req.delay_us + req.period_us);

    // Launch the divider only for an in-range execute.
    assign div_cmd.start    = accept && (req.mode == MODE_EXEC) && in_range;
    assign div_cmd.dividend = next_threshold_reg[req_idx];
    assign div_cmd.divisor  = tick_time_reg;

    // The task is due once its counter has reached the quotient.
    assign due = (tick_counter_reg[exec_idx_reg] >= div_rsp.quotient);

    always_comb
    begin
        state_next     = state_reg;
        exec_idx_next  = exec_idx_reg;
        exec_task_next = exec_task_reg;
        exec_arg_next  = exec_arg_reg;
        res_valid_next = res_valid_reg && !res_take;
        res_fire_next  = res_fire_reg;
        res_task_next  = res_task_reg;
        res_arg_next   = res_arg_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (div_cmd.start)
                    begin
                        state_next     = ST_DIV;
                        exec_idx_next  = req_idx;
                        exec_task_next = req.task_req;
                        exec_arg_next  = req.call_arg;
                    end
                    else
                    begin
                        // Everything but a running execute answers at once without a fire.
                        res_valid_next = 1'b1;
                        res_fire_next  = 1'b0;
                        res_arg_next   = '0;
                        res_task_next  = (req.mode == MODE_CLEAR) ? '0 : req.task_req;
                    end
                end
            end
            ST_DIV:
            begin
                if (div_rsp.done)
                begin
                    state_next     = ST_IDLE;
                    res_valid_next = 1'b1;
                    res_fire_next  = due;
                    res_task_next  = exec_task_reg;
                    res_arg_next   = due ? exec_arg_reg : '0;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State, configuration and the result flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            res_valid_reg <= 1'b0;
            tick_time_reg <= TICK_TIME_RESET;
        end
        else
        begin
            state_reg     <= state_next;
            res_valid_reg <= res_valid_next;
            if (tick_time_we)
            begin
                tick_time_reg <= tick_time_wdata;
            end
        end
    end

    // Payload registers need no reset.
    always_ff @(posedge clk)
    begin
        exec_idx_reg  <= exec_idx_next;
        exec_task_reg <= exec_task_next;
        exec_arg_reg  <= exec_arg_next;
        res_fire_reg  <= res_fire_next;
        res_task_reg  <= res_task_next;
        res_arg_reg   <= res_arg_next;
    end

    // Slot table updates.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < TASKS; i++)
            begin
                tick_counter_reg[i]   <= '0;
                period_store_reg[i]   <= '0;
                next_threshold_reg[i] <= '0;
            end
        end
        else if (state_reg == ST_DIV)
        begin
            if (div_rsp.done && due)
            begin
                tick_counter_reg[exec_idx_reg] <=
                    tick_counter_reg[exec_idx_reg] - div_rsp.quotient;
                next_threshold_reg[exec_idx_reg] <= period_store_reg[exec_idx_reg];
            end
        end
        else if (accept)
        begin
            unique case (req.mode)
                MODE_TICK:
                begin
                    if (in_range)
                    begin
                        tick_counter_reg[req_idx] <= tick_counter_reg[req_idx] + DATA_W'(1);
                    end
                end
                MODE_CLEAR:
                begin
                    for (int i = 0; i < TASKS; i++)
                    begin
                        tick_counter_reg[i] <= '0;
                    end
                end
                MODE_INIT:
                begin
                    if (in_range)
                    begin
                        period_store_reg[req_idx]   <= req.period_us;
                        tick_counter_reg[req_idx]   <= '0;
                        next_threshold_reg[req_idx] <= init_threshold;
                    end
                end
                MODE_EXEC:
                begin
                    // Handled when the division completes.
                end
                default:
                begin
                end
            endcase
        end
    end

    assign res.valid      = res_valid_reg;
    assign res.fire       = res_fire_reg;
    assign res.fired_task = res_task_reg;
    assign res.fired_arg  = res_arg_reg;

endmodule

// ===== dv/periodic_task_tick_scheduler_core_test.sv =====
`timescale 1ns / 1ps
// Self-checking testbench of the periodic task tick scheduler core.
// Depends on ptts_pkg, the ptts_req_if and ptts_res_if interfaces and the core itself.
module periodic_task_tick_scheduler_core_test;
    import ptts_pkg::*;

    // The run is cut off here; a correct run needs a small fraction of it.
    localparam int CYCLE_LIMIT = 500000;
    // Long enough to cover an execute request that is still in flight.
    localparam int DRAIN_CYCLES = 40;
    localparam int HOLD_OFF_CYCLES = 200;
    localparam int IDLE_PERCENT = 21;

    typedef struct packed {
        mode_t             mode;
        logic [TASK_W-1:0] slot;
        logic [DATA_W-1:0] period_us;
        logic [DATA_W-1:0] delay_us;
        logic              immediate_start;
        logic [ARG_W-1:0]  call_arg;
    } sched_req_t;

    typedef struct packed {
        logic              fire;
        logic [TASK_W-1:0] slot;
        logic [ARG_W-1:0]  arg;
    } sched_res_t;

    logic clk;
    logic rst_n;
    logic tick_time_we;
    logic [DATA_W-1:0] tick_time_wdata;

    ptts_req_if req_ch ();
    ptts_res_if res_ch ();

    periodic_task_tick_scheduler_core uut (
        .clk             (clk),
        .rst_n           (rst_n),
        .tick_time_we    (tick_time_we),
        .tick_time_wdata (tick_time_wdata),
        .req             (req_ch.sink),
        .res             (res_ch.source)
    );

    // Requests waiting to be offered, and the results the slot table predicts.
    sched_req_t pending_reqs[$];
    sched_res_t fire_expect_q[$];

    // Our own copy of the slot table and of the tick time register.
    logic [DATA_W-1:0] slot_ticks     [TASKS];
    logic [DATA_W-1:0] slot_period    [TASKS];
    logic [DATA_W-1:0] slot_threshold [TASKS];
    logic [DATA_W-1:0] tick_unit;

    int  mismatches = 0;
    int  cycle_count = 0;
    // While calm is set neither side idles at random.
    bit  calm = 0;
    // The stimulus raises hold_off_go once; the result side then stalls on its own count.
    bit  hold_off_go = 0;
    bit  hold_off_done = 0;
    int  hold_left = 0;

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
    end

    initial
    begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("%0t: timeout after %0d cycles", $time, cycle_count);
        $display("Some tests failed");
        $finish;
    end

    // Applies one accepted request to the slot table and returns the result it yields.
    function automatic sched_res_t schedule_step(sched_req_t r);
        sched_res_t o;
        logic [DATA_W-1:0] quot;
        o.fire = 1'b0;
        o.slot = r.slot;
        o.arg  = '0;
        if (r.mode == MODE_CLEAR)
        begin
            for (int i = 0; i < TASKS; i++)
                slot_ticks[i] = '0;
            o.slot = '0;
        end
        else if (int'(r.slot) < TASKS)
        begin
            case (r.mode)
                MODE_TICK:
                    slot_ticks[r.slot] = slot_ticks[r.slot] + DATA_W'(1);
                MODE_INIT:
                begin
                    slot_period[r.slot] = r.period_us;
                    slot_ticks[r.slot]  = '0;
                    slot_threshold[r.slot] = r.immediate_start ? r.delay_us
                                                               : r.delay_us + r.period_us;
                end
                default:
                begin
                    // A zero tick time behaves like a restoring divider: all ones.
                    quot = (tick_unit == '0) ? '1 : slot_threshold[r.slot] / tick_unit;
                    if (slot_ticks[r.slot] >= quot)
                    begin
                        slot_ticks[r.slot]     = slot_ticks[r.slot] - quot;
                        slot_threshold[r.slot] = slot_period[r.slot];
                        o.fire = 1'b1;
                        o.arg  = r.call_arg;
                    end
                end
            endcase
        end
        return o;
    endfunction

    function automatic sched_req_t make_req(mode_t m, int s, logic [DATA_W-1:0] p,
                                            logic [DATA_W-1:0] d, logic imm,
                                            logic [ARG_W-1:0] a);
        sched_req_t r;
        r.mode = m;
        r.slot = TASK_W'(s);
        r.period_us = p;
        r.delay_us = d;
        r.immediate_start = imm;
        r.call_arg = a;
        return r;
    endfunction

    // Mostly small times scaled to the tick so that tasks come due after a few ticks;
    // now and then a full-range value.
    function automatic logic [DATA_W-1:0] random_time();
        logic [63:0] unit;
        unit = (tick_unit == '0) ? 64'd1 : 64'(tick_unit);
        if ($urandom_range(0, 99) < 80)
            return DATA_W'(unit * $urandom_range(0, 8) + $urandom_range(0, 3));
        return $urandom;
    endfunction

    function automatic sched_req_t random_request();
        sched_req_t r;
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 45)
            r.mode = MODE_TICK;
        else if (roll < 50)
            r.mode = MODE_CLEAR;
        else if (roll < 65)
            r.mode = MODE_INIT;
        else
            r.mode = MODE_EXEC;
        // Half of the traffic goes to two slots so their counters climb.
        r.slot = ($urandom_range(0, 1) == 0) ? TASK_W'($urandom_range(0, 1))
                                             : TASK_W'($urandom_range(0, TASKS - 1));
        r.period_us = random_time();
        r.delay_us = random_time();
        r.immediate_start = 1'($urandom_range(0, 1));
        r.call_arg = ARG_W'($urandom_range(0, 255));
        return r;
    endfunction

    // Request driver: holds an offer until it is taken, predicts on acceptance.
    always @(posedge clk or negedge rst_n)
    begin
        sched_req_t taken;
        bit accepted;
        if (!rst_n)
        begin
            req_ch.valid <= 1'b0;
        end
        else
        begin
            accepted = req_ch.valid && req_ch.ready;
            if (accepted)
            begin
                taken = pending_reqs.pop_front();
                fire_expect_q.push_back(schedule_step(taken));
            end
            if (!req_ch.valid || accepted)
            begin
                if (pending_reqs.size() > 0
                    && (calm || $urandom_range(0, 99) >= IDLE_PERCENT))
                begin
                    req_ch.valid           <= 1'b1;
                    req_ch.mode            <= pending_reqs[0].mode;
                    req_ch.task_req        <= pending_reqs[0].slot;
                    req_ch.period_us       <= pending_reqs[0].period_us;
                    req_ch.delay_us        <= pending_reqs[0].delay_us;
                    req_ch.immediate_start <= pending_reqs[0].immediate_start;
                    req_ch.call_arg        <= pending_reqs[0].call_arg;
                end
                else
                begin
                    req_ch.valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor: checks every accepted result against the oldest prediction.
    always @(posedge clk or negedge rst_n)
    begin
        sched_res_t want;
        if (!rst_n)
        begin
            res_ch.ready <= 1'b0;
        end
        else
        begin
            if (res_ch.valid && res_ch.ready)
            begin
                if (fire_expect_q.size() == 0)
                begin
                    $display("%0t: unexpected result: expected none, actual fire %0b task %0d arg %0h",
                             $time, res_ch.fire, res_ch.fired_task, res_ch.fired_arg);
                    mismatches++;
                end
                else
                begin
                    want = fire_expect_q.pop_front();
                    if (res_ch.fire !== want.fire)
                    begin
                        $display("%0t: fire mismatch: expected %0b actual %0b",
                                 $time, want.fire, res_ch.fire);
                        mismatches++;
                    end
                    if (res_ch.fired_task !== want.slot)
                    begin
                        $display("%0t: fired_task mismatch: expected %0d actual %0d",
                                 $time, want.slot, res_ch.fired_task);
                        mismatches++;
                    end
                    if (res_ch.fired_arg !== want.arg)
                    begin
                        $display("%0t: fired_arg mismatch: expected %0h actual %0h",
                                 $time, want.arg, res_ch.fired_arg);
                        mismatches++;
                    end
                end
            end
            if (hold_left > 0)
            begin
                hold_left <= hold_left - 1;
                res_ch.ready <= 1'b0;
            end
            else if (hold_off_go && !hold_off_done)
            begin
                // One long stall so that the result register fills and the input backs up.
                hold_off_done <= 1'b1;
                hold_left <= HOLD_OFF_CYCLES;
                res_ch.ready <= 1'b0;
            end
            else
            begin
                res_ch.ready <= calm || ($urandom_range(0, 99) >= IDLE_PERCENT);
            end
        end
    end

    // Waits until every request has been offered, taken and answered.
    task automatic wait_drained();
        do
            @(posedge clk);
        while (pending_reqs.size() != 0 || fire_expect_q.size() != 0 || req_ch.valid);
    endtask

    task automatic write_tick_time(logic [DATA_W-1:0] value);
        @(posedge clk);
        tick_time_we    <= 1'b1;
        tick_time_wdata <= value;
        @(posedge clk);
        tick_time_we <= 1'b0;
        tick_unit = value;
    endtask

    task automatic random_phase(int count);
        for (int i = 0; i < count; i++)
            pending_reqs.push_back(random_request());
        wait_drained();
    endtask

    initial
    begin
        rst_n = 1'b0;
        tick_time_we = 1'b0;
        tick_time_wdata = '0;
        req_ch.valid = 1'b0;
        req_ch.mode = MODE_TICK;
        req_ch.task_req = '0;
        req_ch.period_us = '0;
        req_ch.delay_us = '0;
        req_ch.immediate_start = 1'b0;
        req_ch.call_arg = '0;
        res_ch.ready = 1'b0;
        clk = 1'b0;
        tick_unit = TICK_TIME_RESET;
        for (int i = 0; i < TASKS; i++)
        begin
            slot_ticks[i] = '0;
            slot_period[i] = '0;
            slot_threshold[i] = '0;
        end
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part at the reset tick time of 1000 us.
        // A zero threshold is due at once, and stays due since the period is zero too.
        pending_reqs.push_back(make_req(MODE_INIT, 0, '0, '0, 1'b1, 8'h00));
        pending_reqs.push_back(make_req(MODE_EXEC, 0, '0, '0, 1'b0, 8'hA5));
        pending_reqs.push_back(make_req(MODE_EXEC, 0, '0, '0, 1'b0, 8'h5A));
        // Delay plus period wraps at 32 bits and leaves a threshold far out of reach.
        pending_reqs.push_back(make_req(MODE_INIT, 7, '1, '1, 1'b0, 8'h00));
        pending_reqs.push_back(make_req(MODE_EXEC, 7, '1, '1, 1'b1, 8'hFF));
        // Immediate start: the first threshold is 2000 us, two ticks; then 3000 us.
        pending_reqs.push_back(make_req(MODE_INIT, 2, 32'd3000, 32'd2000, 1'b1, 8'h00));
        pending_reqs.push_back(make_req(MODE_TICK, 2, '0, '0, 1'b0, 8'h00));
        pending_reqs.push_back(make_req(MODE_EXEC, 2, '0, '0, 1'b0, 8'h11));
        pending_reqs.push_back(make_req(MODE_TICK, 2, '0, '0, 1'b0, 8'h00));
        pending_reqs.push_back(make_req(MODE_EXEC, 2, '0, '0, 1'b0, 8'hFF));
        for (int i = 0; i < 3; i++)
            pending_reqs.push_back(make_req(MODE_TICK, 2, '0, '0, 1'b0, 8'h00));
        pending_reqs.push_back(make_req(MODE_EXEC, 2, '0, '0, 1'b0, 8'h3C));
        // Clear-all drops the pending tick; its result reports slot zero.
        pending_reqs.push_back(make_req(MODE_INIT, 5, 32'd1000, 32'd999, 1'b0, 8'h00));
        pending_reqs.push_back(make_req(MODE_TICK, 5, '0, '0, 1'b0, 8'h00));
        pending_reqs.push_back(make_req(MODE_CLEAR, 5, '1, '1, 1'b1, 8'hFF));
        pending_reqs.push_back(make_req(MODE_EXEC, 5, '0, '0, 1'b0, 8'h77));
        pending_reqs.push_back(make_req(MODE_TICK, 5, '0, '0, 1'b0, 8'h00));
        pending_reqs.push_back(make_req(MODE_EXEC, 5, '0, '0, 1'b0, 8'h88));
        // Slots never initialized still hold a zero threshold after reset.
        pending_reqs.push_back(make_req(MODE_TICK, 3, '0, '0, 1'b0, 8'h00));
        pending_reqs.push_back(make_req(MODE_EXEC, 3, '0, '0, 1'b0, 8'h00));
        pending_reqs.push_back(make_req(MODE_EXEC, 6, '0, '0, 1'b0, 8'hFF));
        pending_reqs.push_back(make_req(MODE_EXEC, 4, '0, '0, 1'b0, 8'hC3));
        wait_drained();

        // A zero tick time makes every quotient all ones, so nothing comes due.
        write_tick_time('0);
        random_phase(60);

        // The smallest tick time: the quotient equals the threshold itself.
        write_tick_time(32'd1);
        random_phase(150);

        // Neither side idles here, except for the one long stall on the result side.
        calm = 1;
        hold_off_go = 1;
        random_phase(150);
        calm = 0;

        // The largest tick time: almost every threshold divides down to zero.
        write_tick_time('1);
        random_phase(120);

        write_tick_time(DATA_W'($urandom_range(2, 5000)));
        random_phase(150);

        write_tick_time(TICK_TIME_RESET);
        random_phase(70);

        // Any result arriving now has no request behind it and is flagged by the monitor.
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0 && fire_expect_q.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/core/ptts_pkg.sv
rtl/core/ptts_if.sv
rtl/core/ptts_div.sv
rtl/core/periodic_task_tick_scheduler_core.sv
dv/periodic_task_tick_scheduler_core_test.sv
